### sv/gha_pkg.sv
// ----------------------------------------------------------------------------
// gha_pkg
// Shared constants, codes and control types of the generational handle
// allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

  localparam int unsigned MAX_SLOTS = 1024;
  localparam int unsigned IDX_W     = $clog2(MAX_SLOTS);
  localparam int unsigned CNT_W     = IDX_W + 1;
  localparam int unsigned GEN_W     = 8;

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_DESTROY = 2'd1,
    OP_QUERY   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_IGNORED = 2'd2
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic load_item;    // capture request payload
    logic rd_stack;     // read top of free stack
    logic rd_gen_item;  // read generation at request index
    logic rd_gen_pop;   // read generation at popped index
    logic exec;         // update state, load response register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] in_op;
    logic       pop_avail;
    logic       out_free;
  } sts_t;

endpackage

### sv/gha_if.sv
// ----------------------------------------------------------------------------
// gha_if
// Request and response channels of the handle allocator (valid/ready).
// ----------------------------------------------------------------------------
interface gha_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [9:0] handle_index;
  logic [7:0] handle_generation;
  logic       handle_is_null;

  modport source (output valid, operation, handle_index, handle_generation,
                  handle_is_null, input ready);
  modport sink   (input valid, operation, handle_index, handle_generation,
                  handle_is_null, output ready);
endinterface

interface gha_rsp_if;
  logic       valid;
  logic       ready;
  logic [9:0] out_index;
  logic [7:0] out_generation;
  logic       alive;
  logic [1:0] status;

  modport source (output valid, out_index, out_generation, alive, status,
                  input ready);
  modport sink   (input valid, out_index, out_generation, alive, status,
                  output ready);
endinterface

### sv/gha_ram.sv
// ----------------------------------------------------------------------------
// gha_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gha_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/gha_ctrl.sv
// ----------------------------------------------------------------------------
// gha_ctrl
// Request sequencer: issues memory reads, then the state update.
// ----------------------------------------------------------------------------
module gha_ctrl
  import gha_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_EXEC
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_EXEC;
          case (sts_i.in_op)
            OP_CREATE: begin
              if (sts_i.pop_avail) begin
                cmd_o.rd_stack = 1'b1;
                state_d        = S_POP;
              end
            end
            OP_DESTROY, OP_QUERY: cmd_o.rd_gen_item = 1'b1;
            default: ;
          endcase
        end
      end
      S_POP: begin
        // popped index is on the stack read port now
        cmd_o.rd_gen_pop = 1'b1;
        state_d          = S_EXEC;
      end
      S_EXEC: begin
        if (sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### sv/gha_dp.sv
// ----------------------------------------------------------------------------
// gha_dp
// Datapath: request register, generation table, free stack, counters and
// response register.
// ----------------------------------------------------------------------------
module gha_dp
  import gha_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  input  logic [1:0]       operation_i,
  input  logic [IDX_W-1:0] handle_index_i,
  input  logic [GEN_W-1:0] handle_generation_i,
  input  logic             handle_is_null_i,
  input  logic             rsp_ready_i,
  output logic             rsp_valid_o,
  output logic [IDX_W-1:0] out_index_o,
  output logic [GEN_W-1:0] out_generation_o,
  output logic             alive_o,
  output logic [1:0]       status_o
);

  logic [1:0]       op_q;
  logic [IDX_W-1:0] idx_q;
  logic [GEN_W-1:0] gen_q;
  logic             null_q;
  logic [CNT_W-1:0] free_count_q, free_count_d;
  logic [CNT_W-1:0] slots_used_q, slots_used_d;
  logic             rsp_valid_q;
  logic [IDX_W-1:0] out_index_q, out_index_d;
  logic [GEN_W-1:0] out_gen_q, out_gen_d;
  logic             alive_q, alive_d;
  logic [1:0]       status_q, status_d;

  logic [CNT_W-1:0] fc_m1;
  logic [IDX_W-1:0] stack_rdata;
  logic [GEN_W-1:0] gen_rdata;
  logic             gen_we, stack_we;
  logic [IDX_W-1:0] gen_waddr, gen_raddr;
  logic [GEN_W-1:0] gen_wdata;
  logic             live, pop_avail, stack_full, slots_full;

  assign fc_m1      = free_count_q - CNT_W'(1);
  assign pop_avail  = (free_count_q != '0);
  assign stack_full = (free_count_q == CNT_W'(MAX_SLOTS));
  assign slots_full = (slots_used_q == CNT_W'(MAX_SLOTS));
  assign gen_raddr  = cmd_i.rd_gen_pop ? stack_rdata : handle_index_i;

  // table word is only meaningful when the index is in use
  assign live = !null_q && ({1'b0, idx_q} < slots_used_q) && (gen_q == gen_rdata);

  assign sts_o.in_op     = operation_i;
  assign sts_o.pop_avail = pop_avail;
  assign sts_o.out_free  = !rsp_valid_q || rsp_ready_i;

  gha_ram #(.Width(GEN_W), .Depth(MAX_SLOTS)) u_gen_ram (
    .clk_i  (clk_i),
    .we_i   (gen_we),
    .waddr_i(gen_waddr),
    .wdata_i(gen_wdata),
    .re_i   (cmd_i.rd_gen_item || cmd_i.rd_gen_pop),
    .raddr_i(gen_raddr),
    .rdata_o(gen_rdata)
  );

  gha_ram #(.Width(IDX_W), .Depth(MAX_SLOTS)) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (stack_we),
    .waddr_i(free_count_q[IDX_W-1:0]),
    .wdata_i(idx_q),
    .re_i   (cmd_i.rd_stack),
    .raddr_i(fc_m1[IDX_W-1:0]),
    .rdata_o(stack_rdata)
  );

  always_comb begin
    free_count_d = free_count_q;
    slots_used_d = slots_used_q;
    out_index_d  = '0;
    out_gen_d    = '0;
    alive_d      = 1'b0;
    status_d     = ST_OK;
    gen_we       = 1'b0;
    stack_we     = 1'b0;
    gen_waddr    = idx_q;
    gen_wdata    = gen_q + GEN_W'(1);
    case (op_q)
      OP_CREATE: begin
        if (pop_avail) begin
          free_count_d = fc_m1;
          out_index_d  = stack_rdata;
          out_gen_d    = gen_rdata;
        end else if (!slots_full) begin
          out_index_d  = slots_used_q[IDX_W-1:0];
          slots_used_d = slots_used_q + CNT_W'(1);
          gen_we       = cmd_i.exec;
          gen_waddr    = slots_used_q[IDX_W-1:0];
          gen_wdata    = '0;
        end else begin
          status_d = ST_FULL;
        end
      end
      OP_DESTROY: begin
        if (!live) begin
          status_d = ST_IGNORED;
        end else begin
          alive_d = 1'b1;
          if (stack_full) begin
            status_d = ST_IGNORED;
          end else begin
            gen_we       = cmd_i.exec;
            stack_we     = cmd_i.exec;
            free_count_d = free_count_q + CNT_W'(1);
          end
        end
      end
      OP_QUERY: alive_d = live;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q   <= operation_i;
      idx_q  <= handle_index_i;
      gen_q  <= handle_generation_i;
      null_q <= handle_is_null_i;
    end
    if (cmd_i.exec) begin
      out_index_q <= out_index_d;
      out_gen_q   <= out_gen_d;
      alive_q     <= alive_d;
      status_q    <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_count_q <= '0;
      slots_used_q <= '0;
      rsp_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        free_count_q <= free_count_d;
        slots_used_q <= slots_used_d;
        rsp_valid_q  <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_valid_o      = rsp_valid_q;
  assign out_index_o      = out_index_q;
  assign out_generation_o = out_gen_q;
  assign alive_o          = alive_q;
  assign status_o         = status_q;

endmodule

### sv/generational_handle_allocator_core.sv
// ----------------------------------------------------------------------------
// generational_handle_allocator_core
// Generational handle allocator. Create returns a handle (index plus
// generation), reusing the most recently freed index first; destroy retires a
// live handle by bumping its index's generation, unless the free stack is
// full; query reports liveness. One request is in flight at a time. For
// destroy, query and a create of a fresh index, an accepted request goes from
// S_IDLE straight to S_EXEC, which loads the response register, and the next
// request is taken once back in S_IDLE. A create that reuses a freed index
// passes through S_POP in between, because the free-stack read and the
// generation-table read are registered-output memory reads done in sequence.
// A response waiting in the output register does not block acceptance of the
// next request; it only delays that request's final state-update cycle. No
// clearing pass is needed after reset; the first request can be accepted in the first cycle.
// ----------------------------------------------------------------------------
module generational_handle_allocator_core
  import gha_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  gha_req_if.sink   req_i,
  gha_rsp_if.source rsp_o
);

  cmd_t cmd;
  sts_t sts;

  gha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_i.valid),
    .req_ready_o(req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gha_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .operation_i        (req_i.operation),
    .handle_index_i     (req_i.handle_index),
    .handle_generation_i(req_i.handle_generation),
    .handle_is_null_i   (req_i.handle_is_null),
    .rsp_ready_i        (rsp_o.ready),
    .rsp_valid_o        (rsp_o.valid),
    .out_index_o        (rsp_o.out_index),
    .out_generation_o   (rsp_o.out_generation),
    .alive_o            (rsp_o.alive),
    .status_o           (rsp_o.status)
  );

endmodule

### sv/gha_checker.sv
// ----------------------------------------------------------------------------
// gha_checker
// Port-level checks of the handle allocator, bound to the top level.
// ----------------------------------------------------------------------------
module gha_checker
  import gha_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             req_valid_i,
  input logic             req_ready_i,
  input logic             rsp_valid_i,
  input logic             rsp_ready_i,
  input logic [IDX_W-1:0] out_index_i,
  input logic [GEN_W-1:0] out_generation_i,
  input logic             alive_i,
  input logic [1:0]       status_i
);

  // one request in flight: no acceptance right after one
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !req_ready_i)
    else $error("request accepted while another is in flight");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> rsp_valid_i)
    else $error("response dropped before transaction");

  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && status_i == ST_FULL) |->
      (out_index_i == '0 && out_generation_i == '0 && !alive_i))
    else $error("full create returned a handle");

  a_alive_no_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && alive_i) |-> (out_index_i == '0 && out_generation_i == '0))
    else $error("liveness response carries a handle");

endmodule

bind generational_handle_allocator_core gha_checker u_gha_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .out_index_i     (rsp_o.out_index),
  .out_generation_i(rsp_o.out_generation),
  .alive_i         (rsp_o.alive),
  .status_i        (rsp_o.status)
);

### bench/gha_checker.sv
// ----------------------------------------------------------------------------
// gha_scoreboard
// Watches the request and response channels of the handle allocator, keeps a
// shadow of the generation table, the free stack and both counters, and
// compares every response field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module gha_scoreboard
  import gha_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  gha_req_if          req_i,
  gha_rsp_if          rsp_i,
  output int unsigned errors_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [GEN_W-1:0] generation;
    logic             alive;
    status_e          status;
  } alloc_rsp_t;

  logic [GEN_W-1:0] gen_table  [MAX_SLOTS];
  logic [IDX_W-1:0] free_stack [MAX_SLOTS];
  logic [CNT_W-1:0] free_depth;
  logic [CNT_W-1:0] slots_issued;
  alloc_rsp_t       awaited_q[$];

  function automatic bit handle_is_live(logic [IDX_W-1:0] idx, logic [GEN_W-1:0] gen,
                                        logic is_null);
    return !is_null && ({1'b0, idx} < slots_issued) && (gen_table[idx] == gen);
  endfunction

  // Advances the shadow state by one request and returns its response.
  function automatic alloc_rsp_t apply_request(logic [1:0] op, logic [IDX_W-1:0] idx,
                                               logic [GEN_W-1:0] gen, logic is_null);
    alloc_rsp_t       r;
    logic [IDX_W-1:0] slot;
    r = '0;
    case (op)
      OP_CREATE: begin
        if (free_depth != '0) begin
          free_depth   = free_depth - CNT_W'(1);
          slot         = free_stack[free_depth[IDX_W-1:0]];
          r.index      = slot;
          r.generation = gen_table[slot];
        end else if (slots_issued < CNT_W'(MAX_SLOTS)) begin
          r.index = slots_issued[IDX_W-1:0];
          gen_table[slots_issued[IDX_W-1:0]] = '0;
          slots_issued = slots_issued + CNT_W'(1);
        end else begin
          r.status = ST_FULL;
        end
      end
      OP_DESTROY: begin
        if (!handle_is_live(idx, gen, is_null)) begin
          r.status = ST_IGNORED;
        end else begin
          r.alive = 1'b1;
          // a full stack refuses the push, generation stays as is
          if (free_depth >= CNT_W'(MAX_SLOTS)) begin
            r.status = ST_IGNORED;
          end else begin
            gen_table[idx] = gen + GEN_W'(1);
            free_stack[free_depth[IDX_W-1:0]] = idx;
            free_depth = free_depth + CNT_W'(1);
          end
        end
      end
      OP_QUERY: begin
        r.alive = handle_is_live(idx, gen, is_null);
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_rsp_t want;
    if (!rst_ni) begin
      free_depth   = '0;
      slots_issued = '0;
      awaited_q.delete();
      errors_o     = 0;
    end else begin
      // check first: a response never belongs to a request accepted this edge
      if (rsp_i.valid && rsp_i.ready) begin
        if (awaited_q.size() == 0) begin
          $error("unexpected response: index %0d generation %0d alive %0d status %0d",
                 rsp_i.out_index, rsp_i.out_generation, rsp_i.alive, rsp_i.status);
          errors_o++;
        end else begin
          want = awaited_q.pop_front();
          if (rsp_i.out_index !== want.index) begin
            $error("out_index: expected %0d, got %0d", want.index, rsp_i.out_index);
            errors_o++;
          end
          if (rsp_i.out_generation !== want.generation) begin
            $error("out_generation: expected %0d, got %0d", want.generation,
                   rsp_i.out_generation);
            errors_o++;
          end
          if (rsp_i.alive !== want.alive) begin
            $error("alive: expected %0d, got %0d", want.alive, rsp_i.alive);
            errors_o++;
          end
          if (rsp_i.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_i.status);
            errors_o++;
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        awaited_q.insert(awaited_q.size(),
                         apply_request(req_i.operation, req_i.handle_index,
                                       req_i.handle_generation, req_i.handle_is_null));
      end
    end
    pending_o = awaited_q.size();
  end

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the generational handle allocator. A short directed
// sequence hits the corner cases, then one handle is destroyed over and over,
// so its generation wraps and the free stack fills until it refuses a push,
// then random traffic built from handles the block actually returned, with
// bursty requests and a stalling response side.
// ----------------------------------------------------------------------------
module tb_top
  import gha_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] gen;
  } handle_t;

  logic clk;
  logic rst_n;

  gha_req_if req_if ();
  gha_rsp_if rsp_if ();

  int unsigned errors;
  int unsigned pending;

  generational_handle_allocator_core i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  gha_scoreboard i_checker (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .req_i     (req_if),
    .rsp_i     (rsp_if),
    .errors_o  (errors),
    .pending_o (pending)
  );

  // handles the block has handed out, possibly stale by now
  handle_t     handle_pool[$];
  logic [1:0]  issued_ops[$];
  int unsigned n_acc, n_rsp;
  int unsigned n_create, n_destroy, n_query, n_unused;
  int unsigned n_full_refused, n_stack_refused;
  int unsigned burst_left;
  int unsigned cycle_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // response side: rotating stall mask, reloaded now and then
  initial begin
    logic [7:0]  stall_mask;
    int unsigned hold;
    stall_mask = '0;
    hold       = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold == 0) begin
        hold       = 48;
        stall_mask = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom) & 8'h7f;
      end
      hold--;
      rsp_if.ready <= !stall_mask[0];
      stall_mask = {stall_mask[0], stall_mask[7:1]};
    end
  end

  always @(posedge clk) begin
    logic [1:0] op;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      n_rsp++;
      op = (issued_ops.size() != 0) ? issued_ops.pop_front() : OP_UNUSED;
      if (rsp_if.status == ST_FULL) n_full_refused++;
      if (rsp_if.status == ST_IGNORED && rsp_if.alive) n_stack_refused++;
      if (op == OP_CREATE && rsp_if.status == ST_OK) begin
        if (handle_pool.size() >= 2048) handle_pool.delete($urandom_range(2047));
        handle_pool.insert(handle_pool.size(), {rsp_if.out_index, rsp_if.out_generation});
      end
    end
  end

  task automatic send_request(logic [1:0] op, logic [IDX_W-1:0] idx, logic [GEN_W-1:0] gen,
                              logic is_null);
    int unsigned gap;
    if (burst_left == 0) begin
      if ($urandom_range(3) == 0) begin
        burst_left = $urandom_range(40, 80);
        gap        = 0;
      end else begin
        burst_left = $urandom_range(1, 12);
        gap        = $urandom_range(1, 6);
      end
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    req_if.valid             <= 1'b1;
    req_if.operation         <= op;
    req_if.handle_index      <= idx;
    req_if.handle_generation <= gen;
    req_if.handle_is_null    <= is_null;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    burst_left--;
    n_acc++;
    issued_ops.insert(issued_ops.size(), op);
    case (op)
      OP_CREATE:  n_create++;
      OP_DESTROY: n_destroy++;
      OP_QUERY:   n_query++;
      default:    n_unused++;
    endcase
  endtask

  // hold off new requests until every transaction has been answered
  task automatic drain();
    req_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (n_rsp != n_acc) @(posedge clk);
  endtask

  task automatic send_create();
    send_request(OP_CREATE, IDX_W'($urandom), GEN_W'($urandom), 1'($urandom));
  endtask

  task automatic send_destroy_pooled(int unsigned pushback_pct);
    handle_t     h;
    int unsigned k;
    if (handle_pool.size() == 0) begin
      send_create();
    end else begin
      k = $urandom_range(handle_pool.size() - 1);
      h = handle_pool[k];
      handle_pool.delete(k);
      send_request(OP_DESTROY, h.idx, h.gen, ($urandom_range(31) == 0));
      // the freed index already carries the next generation
      if ($urandom_range(99) < pushback_pct) begin
        handle_pool.insert(handle_pool.size(), {h.idx, h.gen + GEN_W'(1)});
      end
    end
  endtask

  task automatic send_query_pooled();
    handle_t     h;
    int unsigned r;
    if (handle_pool.size() == 0) begin
      h = {IDX_W'($urandom), GEN_W'($urandom)};
    end else begin
      h = handle_pool[$urandom_range(handle_pool.size() - 1)];
    end
    r = $urandom_range(9);
    if (r >= 8)      h.gen = GEN_W'($urandom);
    else if (r >= 6) h.gen = h.gen + GEN_W'(1);
    send_request(OP_QUERY, h.idx, h.gen, ($urandom_range(19) == 0));
  endtask

  task automatic send_noise();
    logic [1:0] op;
    op = ($urandom_range(1) == 0) ? OP_UNUSED : 2'($urandom_range(OP_UNUSED));
    send_request(op, IDX_W'($urandom), GEN_W'($urandom), 1'($urandom));
  endtask

  task automatic mixed_item(int unsigned create_pct, int unsigned destroy_pct,
                            int unsigned query_pct, int unsigned pushback_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < create_pct)                                 send_create();
    else if (r < create_pct + destroy_pct)              send_destroy_pooled(pushback_pct);
    else if (r < create_pct + destroy_pct + query_pct)  send_query_pooled();
    else                                                send_noise();
  endtask

  initial begin
    handle_t h;
    req_if.valid             <= 1'b0;
    req_if.operation         <= OP_CREATE;
    req_if.handle_index      <= '0;
    req_if.handle_generation <= '0;
    req_if.handle_is_null    <= 1'b0;
    rst_n                    <= 1'b0;
    burst_left = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed corner cases
    send_request(OP_QUERY,   10'd0,    8'd0,   1'b0);  // nothing issued yet
    send_request(OP_DESTROY, 10'd0,    8'd0,   1'b0);  // not live, ignored
    send_create();                                     // fresh index 0
    send_create();                                     // fresh index 1
    send_request(OP_QUERY,   10'd0,    8'd0,   1'b1);  // null handle
    send_request(OP_QUERY,   10'd0,    8'd0,   1'b0);
    send_request(OP_QUERY,   10'd1,    8'd255, 1'b0);  // wrong generation
    send_request(OP_QUERY,   10'd1023, 8'd255, 1'b0);  // index never issued
    send_request(OP_DESTROY, 10'd0,    8'd0,   1'b0);
    send_request(OP_QUERY,   10'd0,    8'd0,   1'b0);  // stale handle
    send_request(OP_QUERY,   10'd0,    8'd1,   1'b0);  // freed, next generation reads live
    send_request(OP_DESTROY, 10'd0,    8'd1,   1'b0);  // freed slot pushed a second time
    send_request(OP_DESTROY, 10'd0,    8'd1,   1'b0);
    send_request(OP_DESTROY, 10'd1,    8'd0,   1'b1);  // null destroy
    send_request(OP_UNUSED,  10'd1023, 8'd255, 1'b1);
    send_create();                                     // pops index 0
    send_create();                                     // pops index 0 again
    send_create();                                     // fresh index 2
    send_request(OP_DESTROY, 10'd2,    8'd0,   1'b0);
    send_create();
    send_request(OP_QUERY,   10'd2,    8'd1,   1'b0);
    drain();

    // destroy one slot over and over: the generation wraps several times and
    // the free stack fills, so the last live destroy is refused
    send_create();
    drain();
    h = handle_pool[$];
    handle_pool.delete(handle_pool.size() - 1);
    repeat (MAX_SLOTS + 1) begin
      send_request(OP_DESTROY, h.idx, h.gen, 1'b0);
      h.gen = h.gen + GEN_W'(1);
    end
    handle_pool.insert(handle_pool.size(), h);
    drain();

    repeat (200) mixed_item(35, 30, 25, 30);
    drain();
    repeat (8) @(posedge clk);

    if (pending != 0) $error("%0d predicted responses never arrived", pending);
    $display("Ran %0d requests: %0d create, %0d destroy, %0d query, %0d unused code",
             n_acc, n_create, n_destroy, n_query, n_unused);
    $display("Refused creates (no free slot): %0d, refused live destroys (stack full): %0d",
             n_full_refused, n_stack_refused);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
